// ===== design/tpsl_pkg.sv =====
// Package for the tape-port serial link host: command and phase types, mode,
// status and register codes, reset values and the front-to-back queue types.
// No dependencies.
package tpsl_pkg;

  // Field widths
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int CNT_W    = 16;
  localparam int PULSE_W  = 8;
  localparam int BIDX_W   = 5;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_BITS = 8;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Defaults for top-level parameters
  localparam int UNLOCK_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Mode selector codes
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RECV   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNLOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STREAM = 3'd4;

  // Unlock status codes
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SENSE_TO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PULSE_TO = 2'd3;

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_SENSE_TIMEOUT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_PULSE_TIMEOUT = 3'd1;
  localparam logic [ADDR_W-1:0] REG_DELAY_TICKS   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_PULSE_COUNT   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_UNLOCK_CODE   = 3'd4;

  // Register reset values
  localparam logic [CNT_W-1:0]   RST_SENSE_TIMEOUT = 16'd30000;
  localparam logic [CNT_W-1:0]   RST_PULSE_TIMEOUT = 16'd10000;
  localparam logic [CNT_W-1:0]   RST_DELAY_TICKS   = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_PULSE_COUNT   = 8'd100;
  localparam logic [WORD_W-1:0]  RST_UNLOCK_CODE   = 16'hfce2;

  // Classified command of one tick
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SEND,
    CMD_RECV,
    CMD_UNLOCK,
    CMD_STREAM
  } cmd_t;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE, PH_SEND_WAIT, PH_SEND_HI, PH_SEND_LO, PH_SEND_END, PH_SEND_REL,
    PH_RECV_WAIT, PH_RECV_SETTLE, PH_RECV_LO, PH_RECV_HI, PH_RECV_SAMPLE,
    PH_U_D0, PH_U_SLOW, PH_U_D1, PH_U_D2, PH_U_D3, PH_U_D4, PH_U_SHIGH,
    PH_U_D5, PH_U_PULSE, PH_STREAM_D
  } phase_t;

  // One queued tick
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic              sense_in;
    logic              pulse_seen;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== design/tape_port_serial_link_host.sv =====
// Top level of the tape-port serial link host: ties the classifying front end,
// its tick queue and the line sequencer together.
// Depends on tpsl_pkg, tpsl_front and tpsl_back.

// Each input transaction is one timing tick of the link and yields exactly one
// result transaction with the line levels after that tick. The block takes one
// tick per clock cycle while the queue has room: the front end classifies the
// mode and pushes the tick into a QUEUE_DEPTH-entry queue, and the sequencer
// retires one queued tick per cycle while the output is free, so a tick is
// registered in its queue entry and its result then in m_tdata. Throughput
// drops only when the output register is held by m_tready low; the queue then
// absorbs up to QUEUE_DEPTH ticks before s_tready falls. Configuration writes
// take effect on the next edge and are meant for idle periods. UNLOCK_BITS
// (8 to 16) sets how many low bits of the unlock code are shifted out.
module tape_port_serial_link_host #(
  parameter int UNLOCK_BITS = tpsl_pkg::UNLOCK_BITS_DEF,
  parameter int QUEUE_DEPTH = tpsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tx_byte [7:0], sense_in [8], pulse_seen [9], zero fill [15:10]
  input  logic [tpsl_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode [2:0]
  input  logic [tpsl_pkg::MODE_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // motor_on [0], write_level [1], sense_drive [2], sense_level [3],
  // busy_res [4], done_res [5], rx_byte [13:6], status [15:14]
  output logic [tpsl_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [tpsl_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [tpsl_pkg::WORD_W-1:0]      cfg_data
);

  tpsl_pkg::queue_head_t head;
  logic                  pop;

  tpsl_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  tpsl_back #(
    .UNLOCK_BITS (UNLOCK_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  // A finished command leaves the sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> !m_tdata[4])
    else $error("done reported while still busy");

  // Status and received byte appear only on the finishing tick
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[15:14] != tpsl_pkg::ST_NONE) || (m_tdata[13:6] != '0)))
      |-> m_tdata[5])
    else $error("status or rx byte without done");

  // A full queue always offers work to the sequencer
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> head.valid)
    else $error("queue reports full but has no head entry");

  // The queue is popped only when it holds a tick
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== design/tpsl_front.sv =====
// Front end of the tape-port link host: accepts tick transactions, classifies
// the mode selector into a command and holds them in a short queue.
// Depends on tpsl_pkg.
module tpsl_front #(
  parameter int QUEUE_DEPTH = tpsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tx_byte [7:0], sense_in [8], pulse_seen [9], zero fill [15:10]
  input  logic [tpsl_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode [2:0]
  input  logic [tpsl_pkg::MODE_W-1:0]      s_tuser,
  output tpsl_pkg::queue_head_t            head,
  input  logic                             pop
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  tpsl_pkg::item_t     entries [QUEUE_DEPTH];
  tpsl_pkg::item_t     in_item;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [COUNT_W-1:0]  count;
  logic                push;
  logic                do_pop;

  // Classify the mode selector
  always_comb begin
    in_item.tx_byte    = s_tdata[tpsl_pkg::BYTE_W-1:0];
    in_item.sense_in   = s_tdata[tpsl_pkg::BYTE_W];
    in_item.pulse_seen = s_tdata[tpsl_pkg::BYTE_W+1];
    unique case (s_tuser)
      tpsl_pkg::MODE_SEND:   in_item.cmd = tpsl_pkg::CMD_SEND;
      tpsl_pkg::MODE_RECV:   in_item.cmd = tpsl_pkg::CMD_RECV;
      tpsl_pkg::MODE_UNLOCK: in_item.cmd = tpsl_pkg::CMD_UNLOCK;
      tpsl_pkg::MODE_STREAM: in_item.cmd = tpsl_pkg::CMD_STREAM;
      default:               in_item.cmd = tpsl_pkg::CMD_NONE;
    endcase
  end

  assign s_tready   = (count != COUNT_W'(QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  // Store incoming ticks
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/tpsl_back.sv =====
// Back end of the tape-port link host: configuration registers, the result
// register, and the line sequencer: one queued tick per cycle when unstalled.
// Depends on tpsl_pkg.
module tpsl_back #(
  parameter int UNLOCK_BITS = tpsl_pkg::UNLOCK_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpsl_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [tpsl_pkg::WORD_W-1:0]      cfg_data,
  input  tpsl_pkg::queue_head_t            head,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // motor_on [0], write_level [1], sense_drive [2], sense_level [3],
  // busy_res [4], done_res [5], rx_byte [13:6], status [15:14]
  output logic [tpsl_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // Configuration registers
  logic [tpsl_pkg::CNT_W-1:0]   sense_timeout;
  logic [tpsl_pkg::CNT_W-1:0]   pulse_timeout;
  logic [tpsl_pkg::CNT_W-1:0]   delay_ticks;
  logic [tpsl_pkg::PULSE_W-1:0] pulse_count;
  logic [tpsl_pkg::WORD_W-1:0]  unlock_code;

  // Sequencer state
  tpsl_pkg::phase_t             phase, phase_next;
  logic [tpsl_pkg::WORD_W-1:0]  shift_reg, shift_reg_next;
  logic [tpsl_pkg::BIDX_W-1:0]  bit_index, bit_index_next;
  logic [tpsl_pkg::CNT_W-1:0]   wait_counter, wait_counter_next;
  logic [tpsl_pkg::PULSE_W-1:0] pulses_left, pulses_left_next;
  logic motor, motor_next;
  logic wr_line, wr_line_next;
  logic drive, drive_next;
  logic level, level_next;

  // Per-tick results
  logic                          done;
  logic [tpsl_pkg::BYTE_W-1:0]   rx;
  logic [tpsl_pkg::STATUS_W-1:0] status;
  logic                          advance;
  logic                          cnt_exp;
  logic [tpsl_pkg::CNT_W-1:0]    cnt_dec;
  logic [tpsl_pkg::BIDX_W-1:0]   bidx_inc;
  logic [tpsl_pkg::WORD_W-1:0]   code_aligned;
  logic [tpsl_pkg::WORD_W-1:0]   shift_left;
  tpsl_pkg::item_t               it;

  assign it           = head.item;
  assign advance      = head.valid && (!m_tvalid || m_tready);
  assign pop          = advance;
  assign cnt_exp      = (wait_counter <= tpsl_pkg::CNT_W'(1));
  assign cnt_dec      = wait_counter - 1'b1;
  assign bidx_inc     = bit_index + 1'b1;
  assign shift_left   = {shift_reg[tpsl_pkg::WORD_W-2:0], 1'b0};
  assign code_aligned = tpsl_pkg::WORD_W'(unlock_code << (tpsl_pkg::WORD_W - UNLOCK_BITS));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sense_timeout <= tpsl_pkg::RST_SENSE_TIMEOUT;
      pulse_timeout <= tpsl_pkg::RST_PULSE_TIMEOUT;
      delay_ticks   <= tpsl_pkg::RST_DELAY_TICKS;
      pulse_count   <= tpsl_pkg::RST_PULSE_COUNT;
      unlock_code   <= tpsl_pkg::RST_UNLOCK_CODE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tpsl_pkg::REG_SENSE_TIMEOUT: sense_timeout <= cfg_data;
        tpsl_pkg::REG_PULSE_TIMEOUT: pulse_timeout <= cfg_data;
        tpsl_pkg::REG_DELAY_TICKS:   delay_ticks   <= cfg_data;
        tpsl_pkg::REG_PULSE_COUNT:   pulse_count   <= cfg_data[tpsl_pkg::PULSE_W-1:0];
        tpsl_pkg::REG_UNLOCK_CODE:   unlock_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tpsl_pkg::PH_IDLE;
      shift_reg    <= '0;
      bit_index    <= '0;
      wait_counter <= '0;
      pulses_left  <= '0;
      motor        <= 1'b0;
      wr_line      <= 1'b0;
      drive        <= 1'b0;
      level        <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      shift_reg    <= shift_reg_next;
      bit_index    <= bit_index_next;
      wait_counter <= wait_counter_next;
      pulses_left  <= pulses_left_next;
      motor        <= motor_next;
      wr_line      <= wr_line_next;
      drive        <= drive_next;
      level        <= level_next;
    end
  end

  // Next phase and line levels for one tick
  always_comb begin
    phase_next        = phase;
    shift_reg_next    = shift_reg;
    bit_index_next    = bit_index;
    wait_counter_next = wait_counter;
    pulses_left_next  = pulses_left;
    motor_next        = motor;
    wr_line_next      = wr_line;
    drive_next        = drive;
    level_next        = level;
    done              = 1'b0;
    rx                = '0;
    status            = tpsl_pkg::ST_NONE;
    unique case (phase)
      tpsl_pkg::PH_IDLE: begin
        unique case (it.cmd)
          tpsl_pkg::CMD_SEND: begin
            shift_reg_next = tpsl_pkg::WORD_W'(it.tx_byte);
            bit_index_next = '0;
            phase_next     = tpsl_pkg::PH_SEND_WAIT;
          end
          tpsl_pkg::CMD_RECV: begin
            shift_reg_next = '0;
            bit_index_next = '0;
            phase_next     = tpsl_pkg::PH_RECV_WAIT;
          end
          tpsl_pkg::CMD_UNLOCK: begin
            shift_reg_next    = code_aligned;
            bit_index_next    = '0;
            wr_line_next      = 1'b0;
            motor_next        = 1'b1;
            wait_counter_next = delay_ticks;
            phase_next        = tpsl_pkg::PH_U_D0;
          end
          tpsl_pkg::CMD_STREAM: begin
            motor_next        = 1'b1;
            wait_counter_next = delay_ticks;
            phase_next        = tpsl_pkg::PH_STREAM_D;
          end
          default: ;
        endcase
      end
      tpsl_pkg::PH_SEND_WAIT: begin
        if (it.sense_in) begin
          drive_next = 1'b1;
          phase_next = tpsl_pkg::PH_SEND_HI;
        end
      end
      tpsl_pkg::PH_SEND_HI: begin
        level_next   = shift_reg[tpsl_pkg::DATA_BITS-1];
        wr_line_next = 1'b1;
        phase_next   = tpsl_pkg::PH_SEND_LO;
      end
      tpsl_pkg::PH_SEND_LO: begin
        wr_line_next   = 1'b0;
        shift_reg_next = {{(tpsl_pkg::WORD_W-tpsl_pkg::DATA_BITS){1'b0}},
                          shift_left[tpsl_pkg::DATA_BITS-1:0]};
        bit_index_next = bidx_inc;
        phase_next     = (bidx_inc >= tpsl_pkg::BIDX_W'(tpsl_pkg::DATA_BITS)) ?
                         tpsl_pkg::PH_SEND_END : tpsl_pkg::PH_SEND_HI;
      end
      tpsl_pkg::PH_SEND_END: begin
        level_next = 1'b1;
        phase_next = tpsl_pkg::PH_SEND_REL;
      end
      tpsl_pkg::PH_SEND_REL: begin
        level_next = 1'b0;
        drive_next = 1'b0;
        done       = 1'b1;
        phase_next = tpsl_pkg::PH_IDLE;
      end
      tpsl_pkg::PH_RECV_WAIT: begin
        if (it.sense_in) begin
          wr_line_next = 1'b1;
          phase_next   = tpsl_pkg::PH_RECV_SETTLE;
        end
      end
      tpsl_pkg::PH_RECV_SETTLE: phase_next = tpsl_pkg::PH_RECV_LO;
      tpsl_pkg::PH_RECV_LO: begin
        wr_line_next = 1'b0;
        phase_next   = tpsl_pkg::PH_RECV_HI;
      end
      tpsl_pkg::PH_RECV_HI: begin
        wr_line_next = 1'b1;
        phase_next   = tpsl_pkg::PH_RECV_SAMPLE;
      end
      tpsl_pkg::PH_RECV_SAMPLE: begin
        shift_reg_next = {{(tpsl_pkg::WORD_W-tpsl_pkg::DATA_BITS){1'b0}},
                          shift_reg[tpsl_pkg::DATA_BITS-2:0], it.sense_in};
        bit_index_next = bidx_inc;
        if (bidx_inc >= tpsl_pkg::BIDX_W'(tpsl_pkg::DATA_BITS)) begin
          wr_line_next = 1'b0;
          rx           = shift_reg_next[tpsl_pkg::BYTE_W-1:0];
          done         = 1'b1;
          phase_next   = tpsl_pkg::PH_IDLE;
        end else begin
          phase_next = tpsl_pkg::PH_RECV_LO;
        end
      end
      tpsl_pkg::PH_U_D0: begin
        if (cnt_exp) begin
          wait_counter_next = sense_timeout;
          phase_next        = tpsl_pkg::PH_U_SLOW;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_SLOW: begin
        if (!it.sense_in) begin
          motor_next        = 1'b0;
          wait_counter_next = delay_ticks;
          phase_next        = tpsl_pkg::PH_U_D1;
        end else if (cnt_exp) begin
          status     = tpsl_pkg::ST_SENSE_TO;
          done       = 1'b1;
          phase_next = tpsl_pkg::PH_IDLE;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_D1: begin
        if (cnt_exp) begin
          wr_line_next      = shift_reg[tpsl_pkg::WORD_W-1];
          shift_reg_next    = shift_left;
          bit_index_next    = bidx_inc;
          wait_counter_next = delay_ticks;
          phase_next        = tpsl_pkg::PH_U_D2;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_D2: begin
        if (cnt_exp) begin
          motor_next        = 1'b1;
          wait_counter_next = delay_ticks;
          phase_next        = tpsl_pkg::PH_U_D3;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_D3: begin
        if (cnt_exp) begin
          motor_next        = 1'b0;
          wait_counter_next = delay_ticks;
          if (bit_index < tpsl_pkg::BIDX_W'(UNLOCK_BITS)) begin
            // Shift out the next code bit
            wr_line_next   = shift_reg[tpsl_pkg::WORD_W-1];
            shift_reg_next = shift_left;
            bit_index_next = bidx_inc;
            phase_next     = tpsl_pkg::PH_U_D2;
          end else begin
            phase_next = tpsl_pkg::PH_U_D4;
          end
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_D4: begin
        if (cnt_exp) begin
          wr_line_next      = 1'b1;
          wait_counter_next = sense_timeout;
          phase_next        = tpsl_pkg::PH_U_SHIGH;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_SHIGH: begin
        if (it.sense_in) begin
          wait_counter_next = delay_ticks;
          phase_next        = tpsl_pkg::PH_U_D5;
        end else if (cnt_exp) begin
          status     = tpsl_pkg::ST_SENSE_TO;
          done       = 1'b1;
          phase_next = tpsl_pkg::PH_IDLE;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_D5: begin
        if (cnt_exp) begin
          pulses_left_next  = pulse_count;
          wait_counter_next = pulse_timeout;
          phase_next        = tpsl_pkg::PH_U_PULSE;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_U_PULSE: begin
        if (it.pulse_seen) begin
          if (pulses_left <= tpsl_pkg::PULSE_W'(1)) begin
            pulses_left_next = '0;
            wr_line_next     = 1'b0;
            status           = tpsl_pkg::ST_OK;
            done             = 1'b1;
            phase_next       = tpsl_pkg::PH_IDLE;
          end else begin
            pulses_left_next  = pulses_left - 1'b1;
            wait_counter_next = pulse_timeout;
          end
        end else if (cnt_exp) begin
          status     = tpsl_pkg::ST_PULSE_TO;
          done       = 1'b1;
          phase_next = tpsl_pkg::PH_IDLE;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      tpsl_pkg::PH_STREAM_D: begin
        if (cnt_exp) begin
          done       = 1'b1;
          phase_next = tpsl_pkg::PH_IDLE;
        end else begin
          wait_counter_next = cnt_dec;
        end
      end
      default: phase_next = tpsl_pkg::PH_IDLE;
    endcase
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture the result of each tick
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {status, rx, done, (phase_next != tpsl_pkg::PH_IDLE),
                  level_next, drive_next, wr_line_next, motor_next};
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for tape_port_serial_link_host: plans link ticks (commands plus
// line activity), mirrors the sequencer to predict the line levels and compares every result.
// Depends on tpsl_pkg and the RTL of tape_port_serial_link_host.
module testbench;
  import tpsl_pkg::*;

  localparam int UL_BITS      = UNLOCK_BITS_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 200;
  localparam int RAND_PHASES  = 3;
  localparam int PHASE_TICKS  = 200;
  localparam int NFIELDS      = 8;

  // Mode values the block has no command for
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef enum int {UL_PASS, UL_SLOW_TO, UL_SHIGH_TO, UL_PULSE_TO} unlock_plan_t;

  // One link tick as planned
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] tx;
    logic              sense;
    logic              pulse;
  } link_tick_t;

  // Line levels after one tick, laid out as m_tdata
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   rx;
    logic                done;
    logic                busy;
    logic                level;
    logic                drive;
    logic                wr;
    logic                motor;
  } link_out_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [ADDR_W-1:0]     cfg_addr = '0;
  logic [WORD_W-1:0]     cfg_data = '0;

  tape_port_serial_link_host #(
    .UNLOCK_BITS(UL_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // Planned ticks and predicted line levels
  link_tick_t  pending_ticks[$];
  link_out_t   expected_lines[$];
  link_tick_t  held_tick;
  link_out_t   pred_lines;
  bit          tick_held = 1'b0;
  int unsigned plan_cnt = 0;
  int          fail_cnt = 0;
  int          results_seen = 0;
  int          cyc = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  // Register copies
  logic [CNT_W-1:0]   cfg_sense_to = RST_SENSE_TIMEOUT;
  logic [CNT_W-1:0]   cfg_pulse_to = RST_PULSE_TIMEOUT;
  logic [CNT_W-1:0]   cfg_delay    = RST_DELAY_TICKS;
  logic [PULSE_W-1:0] cfg_pcount   = RST_PULSE_COUNT;
  logic [WORD_W-1:0]  cfg_code     = RST_UNLOCK_CODE;

  // Sequencer copy
  phase_t             seq_ph = PH_IDLE;
  logic [WORD_W-1:0]  seq_shift = '0;
  logic [BIDX_W-1:0]  seq_bits = '0;
  logic [CNT_W-1:0]   seq_wait = '0;
  logic [PULSE_W-1:0] seq_pulses = '0;
  logic ln_motor = 1'b0, ln_write = 1'b0, ln_drive = 1'b0, ln_level = 1'b0;

  string fld_name [NFIELDS] = '{"motor_on", "write_level", "sense_drive", "sense_level",
                                "busy_res", "done_res", "rx_byte", "status"};
  int    fld_lo   [NFIELDS] = '{0, 1, 2, 3, 4, 5, 6, 14};
  int    fld_w    [NFIELDS] = '{1, 1, 1, 1, 1, 1, 8, 2};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // True when the running countdown ends on this tick
  function automatic bit wait_expired();
    if (seq_wait <= 16'd1) return 1'b1;
    seq_wait = seq_wait - 16'd1;
    return 1'b0;
  endfunction

  // Put the next unlock bit on write and start the settling delay
  function automatic void shift_out_bit();
    ln_write  = seq_shift[WORD_W-1];
    seq_shift = seq_shift << 1;
    seq_bits  = seq_bits + 1'b1;
    seq_wait  = cfg_delay;
    seq_ph    = PH_U_D2;
  endfunction

  // Advance the sequencer copy by one tick and return the line levels
  task automatic advance_link(input link_tick_t t, output link_out_t r);
    logic                done;
    logic [BYTE_W-1:0]   rx;
    logic [STATUS_W-1:0] st;
    done = 1'b0;
    rx   = '0;
    st   = ST_NONE;
    case (seq_ph)
      PH_IDLE: begin
        if (t.mode == MODE_SEND) begin
          seq_shift = {8'h00, t.tx};
          seq_bits  = '0;
          seq_ph    = PH_SEND_WAIT;
        end else if (t.mode == MODE_RECV) begin
          seq_shift = '0;
          seq_bits  = '0;
          seq_ph    = PH_RECV_WAIT;
        end else if (t.mode == MODE_UNLOCK) begin
          seq_shift = cfg_code << (WORD_W - UL_BITS);
          seq_bits  = '0;
          ln_write  = 1'b0;
          ln_motor  = 1'b1;
          seq_wait  = cfg_delay;
          seq_ph    = PH_U_D0;
        end else if (t.mode == MODE_STREAM) begin
          ln_motor = 1'b1;
          seq_wait = cfg_delay;
          seq_ph   = PH_STREAM_D;
        end
      end
      PH_SEND_WAIT: begin
        if (t.sense) begin
          ln_drive = 1'b1;
          seq_ph   = PH_SEND_HI;
        end
      end
      PH_SEND_HI: begin
        ln_level = seq_shift[7];
        ln_write = 1'b1;
        seq_ph   = PH_SEND_LO;
      end
      PH_SEND_LO: begin
        ln_write  = 1'b0;
        seq_shift = {8'h00, seq_shift[6:0], 1'b0};
        seq_bits  = seq_bits + 1'b1;
        seq_ph    = (seq_bits >= DATA_BITS) ? PH_SEND_END : PH_SEND_HI;
      end
      PH_SEND_END: begin
        ln_level = 1'b1;
        seq_ph   = PH_SEND_REL;
      end
      PH_SEND_REL: begin
        ln_level = 1'b0;
        ln_drive = 1'b0;
        done     = 1'b1;
        seq_ph   = PH_IDLE;
      end
      PH_RECV_WAIT: begin
        if (t.sense) begin
          ln_write = 1'b1;
          seq_ph   = PH_RECV_SETTLE;
        end
      end
      PH_RECV_SETTLE: seq_ph = PH_RECV_LO;
      PH_RECV_LO: begin
        ln_write = 1'b0;
        seq_ph   = PH_RECV_HI;
      end
      PH_RECV_HI: begin
        ln_write = 1'b1;
        seq_ph   = PH_RECV_SAMPLE;
      end
      PH_RECV_SAMPLE: begin
        seq_shift = {8'h00, seq_shift[6:0], t.sense};
        seq_bits  = seq_bits + 1'b1;
        if (seq_bits >= DATA_BITS) begin
          ln_write = 1'b0;
          rx       = seq_shift[7:0];
          done     = 1'b1;
          seq_ph   = PH_IDLE;
        end else begin
          seq_ph = PH_RECV_LO;
        end
      end
      PH_U_D0: begin
        if (wait_expired()) begin
          seq_wait = cfg_sense_to;
          seq_ph   = PH_U_SLOW;
        end
      end
      PH_U_SLOW: begin
        if (!t.sense) begin
          ln_motor = 1'b0;
          seq_wait = cfg_delay;
          seq_ph   = PH_U_D1;
        end else if (wait_expired()) begin
          st     = ST_SENSE_TO;
          done   = 1'b1;
          seq_ph = PH_IDLE;
        end
      end
      PH_U_D1: begin
        if (wait_expired()) shift_out_bit();
      end
      PH_U_D2: begin
        if (wait_expired()) begin
          ln_motor = 1'b1;
          seq_wait = cfg_delay;
          seq_ph   = PH_U_D3;
        end
      end
      PH_U_D3: begin
        if (wait_expired()) begin
          ln_motor = 1'b0;
          if (seq_bits < UL_BITS) begin
            shift_out_bit();
          end else begin
            seq_wait = cfg_delay;
            seq_ph   = PH_U_D4;
          end
        end
      end
      PH_U_D4: begin
        if (wait_expired()) begin
          ln_write = 1'b1;
          seq_wait = cfg_sense_to;
          seq_ph   = PH_U_SHIGH;
        end
      end
      PH_U_SHIGH: begin
        if (t.sense) begin
          seq_wait = cfg_delay;
          seq_ph   = PH_U_D5;
        end else if (wait_expired()) begin
          st     = ST_SENSE_TO;
          done   = 1'b1;
          seq_ph = PH_IDLE;
        end
      end
      PH_U_D5: begin
        if (wait_expired()) begin
          seq_pulses = cfg_pcount;
          seq_wait   = cfg_pulse_to;
          seq_ph     = PH_U_PULSE;
        end
      end
      PH_U_PULSE: begin
        if (t.pulse) begin
          if (seq_pulses <= 8'd1) begin
            seq_pulses = '0;
            ln_write   = 1'b0;
            st         = ST_OK;
            done       = 1'b1;
            seq_ph     = PH_IDLE;
          end else begin
            seq_pulses = seq_pulses - 8'd1;
            seq_wait   = cfg_pulse_to;
          end
        end else if (wait_expired()) begin
          st     = ST_PULSE_TO;
          done   = 1'b1;
          seq_ph = PH_IDLE;
        end
      end
      PH_STREAM_D: begin
        if (wait_expired()) begin
          done   = 1'b1;
          seq_ph = PH_IDLE;
        end
      end
      default: seq_ph = PH_IDLE;
    endcase
    r.status = st;
    r.rx     = rx;
    r.done   = done;
    r.busy   = (seq_ph != PH_IDLE);
    r.level  = ln_level;
    r.drive  = ln_drive;
    r.wr     = ln_write;
    r.motor  = ln_motor;
  endtask

  // Register write through the config port; the copy follows at the same edge
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SENSE_TIMEOUT: cfg_sense_to = val;
      REG_PULSE_TIMEOUT: cfg_pulse_to = val;
      REG_DELAY_TICKS:   cfg_delay    = val;
      REG_PULSE_COUNT:   cfg_pcount   = val[PULSE_W-1:0];
      REG_UNLOCK_CODE:   cfg_code     = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CNT_W-1:0] sense_to, input logic [CNT_W-1:0] pulse_to,
                             input logic [CNT_W-1:0] delay, input logic [PULSE_W-1:0] pcount,
                             input logic [WORD_W-1:0] code);
    write_reg(REG_SENSE_TIMEOUT, sense_to);
    write_reg(REG_PULSE_TIMEOUT, pulse_to);
    write_reg(REG_DELAY_TICKS, delay);
    write_reg(REG_PULSE_COUNT, {8'h00, pcount});
    write_reg(REG_UNLOCK_CODE, code);
  endtask

  function automatic void push_tick(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] tx,
                                    input logic s, input logic p);
    link_tick_t t;
    t.mode  = m;
    t.tx    = tx;
    t.sense = s;
    t.pulse = p;
    pending_ticks.push_back(t);
    plan_cnt++;
  endfunction

  // Mostly plain ticks, sometimes a command that a busy sequencer must ignore;
  // unlock and stream stay out while the settling delay is long
  function automatic logic [MODE_W-1:0] body_mode();
    logic [MODE_W-1:0] m;
    if ($urandom_range(99) >= 10) return MODE_TICK;
    m = MODE_W'($urandom_range(7));
    if (cfg_delay > 16'd16 && (m == MODE_UNLOCK || m == MODE_STREAM)) return MODE_TICK;
    return m;
  endfunction

  function automatic int at_least_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Send: hold sense low for a while, then ready for the whole byte
  function automatic void plan_send(input logic [BYTE_W-1:0] tx, input int wait_n);
    push_tick(MODE_SEND, tx, 1'($urandom), 1'($urandom));
    for (int i = 0; i < wait_n; i++) push_tick(body_mode(), 8'($urandom), 1'b0, 1'($urandom));
    for (int i = 0; i < 20; i++) push_tick(body_mode(), 8'($urandom), 1'b1, 1'($urandom));
  endfunction

  // Receive: ready tick, then the byte's bits on the sampling ticks, MSB first
  function automatic void plan_recv(input int wait_n, input logic [BYTE_W-1:0] pattern);
    logic s;
    push_tick(MODE_RECV, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int i = 0; i < wait_n; i++) push_tick(body_mode(), 8'($urandom), 1'b0, 1'($urandom));
    push_tick(body_mode(), 8'($urandom), 1'b1, 1'($urandom));
    for (int k = 1; k <= 26; k++) begin
      s = 1'($urandom);
      if (k >= 4 && k <= 25 && k % 3 == 1) s = pattern[7 - (k - 4) / 3];
      push_tick(body_mode(), 8'($urandom), s, 1'($urandom));
    end
  endfunction

  // Unlock: sense low for the slow check, high for the ready check, then read pulses
  function automatic void plan_unlock(input unlock_plan_t plan);
    int d, stt, ptt, pc, pulse_at, len, low_end, burst;
    logic s, p;
    d        = at_least_one(cfg_delay);
    stt      = at_least_one(cfg_sense_to);
    ptt      = at_least_one(cfg_pulse_to);
    pc       = at_least_one(cfg_pcount);
    pulse_at = 36 * d + 3;
    low_end  = d + 1 + $urandom_range(d);
    burst    = $urandom_range(pc - 1);
    case (plan)
      UL_SLOW_TO:  len = d + stt + 3;
      UL_SHIGH_TO: len = 35 * d + stt + 5;
      UL_PASS:     len = pulse_at + 2 * pc + ((ptt < 8) ? ptt : 8) + 4;
      default:     len = pulse_at + pc + ptt + 4;
    endcase
    push_tick(MODE_UNLOCK, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int i = 1; i < len; i++) begin
      p = 1'($urandom);
      case (plan)
        UL_SLOW_TO:  s = 1'b1;
        UL_SHIGH_TO: s = 1'b0;
        default:     s = (i > low_end);
      endcase
      if (i >= pulse_at && plan == UL_PASS) p = (ptt <= 2) || ($urandom_range(3) != 0);
      if (i >= pulse_at && plan == UL_PULSE_TO) p = (i < pulse_at + burst);
      push_tick(body_mode(), 8'($urandom), s, p);
    end
  endfunction

  function automatic void plan_stream();
    push_tick(MODE_STREAM, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int i = 0; i < at_least_one(cfg_delay) + 2; i++) begin
      push_tick(body_mode(), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endfunction

  // Wait until every planned tick is accepted and its result checked
  task automatic drain();
    @(posedge clk);
    while (pending_ticks.size() != 0 || tick_held || expected_lines.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Run the sequencer back to idle so registers can be rewritten
  task automatic settle();
    logic s;
    drain();
    while (seq_ph != PH_IDLE) begin
      s = (seq_ph != PH_U_SLOW);
      for (int i = 0; i < 256; i++) push_tick(MODE_TICK, 8'($urandom), s, 1'b1);
      drain();
    end
    repeat (4) @(posedge clk);
  endtask

  // Stimulus plan
  initial begin
    int unsigned base, pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle ticks, unused modes, byte transfers
    push_tick(MODE_TICK, 8'hff, 1'b1, 1'b1);
    push_tick(MODE_RSVD5, 8'h00, 1'b0, 1'b0);
    push_tick(MODE_RSVD6, 8'hff, 1'b1, 1'b0);
    push_tick(MODE_RSVD7, 8'h00, 1'b0, 1'b1);
    plan_send(8'ha5, 3);
    plan_send(8'h00, 0);
    plan_send(8'hff, 1);
    plan_recv(2, 8'h5a);
    plan_recv(0, 8'hff);
    plan_recv(1, 8'h00);
    settle();

    // Writes past the last register must be dropped
    for (int k = REG_UNLOCK_CODE + 1; k < (1 << ADDR_W); k++) write_reg(ADDR_W'(k), 16'hffff);

    // Smallest settings: every unlock outcome
    load_config(16'd1, 16'd1, 16'd1, 8'd1, 16'h0000);
    plan_unlock(UL_PASS);
    plan_unlock(UL_SLOW_TO);
    plan_unlock(UL_SHIGH_TO);
    plan_unlock(UL_PULSE_TO);
    plan_send(8'hff, 0);
    plan_recv(0, 8'h00);
    settle();

    // Zero in every counter behaves as one
    load_config(16'd0, 16'd0, 16'd0, 8'd0, 16'hffff);
    plan_unlock(UL_PASS);
    plan_unlock(UL_PULSE_TO);
    plan_stream();
    settle();

    // Largest timeouts and pulse count
    load_config(16'hffff, 16'hffff, 16'd1, 8'hff, 16'h8001);
    plan_unlock(UL_PASS);
    settle();

    // Random command sequences under random small settings
    for (int rp = 0; rp < RAND_PHASES; rp++) begin
      load_config(CNT_W'($urandom_range(12)), CNT_W'($urandom_range(6)),
                  CNT_W'($urandom_range(2)), PULSE_W'($urandom_range(8)), 16'($urandom));
      if ($urandom_range(3) == 0) begin
        write_reg(ADDR_W'($urandom_range((1 << ADDR_W) - 1, REG_UNLOCK_CODE + 1)),
                  16'($urandom));
      end
      calm <= (rp == 2);
      base = plan_cnt;
      while (plan_cnt - base < PHASE_TICKS) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          plan_send(8'($urandom), $urandom_range(3));
        end else if (pick < 45) begin
          plan_recv($urandom_range(3), 8'($urandom));
        end else if (pick < 75) begin
          pick = $urandom_range(99);
          if (pick < 55) plan_unlock(UL_PASS);
          else if (pick < 70) plan_unlock(UL_SLOW_TO);
          else if (pick < 85) plan_unlock(UL_SHIGH_TO);
          else plan_unlock(UL_PULSE_TO);
        end else if (pick < 85) begin
          plan_stream();
        end else begin
          for (int i = 0; i < $urandom_range(12, 1); i++) begin
            push_tick(MODE_W'($urandom_range(7)), 8'($urandom), 1'($urandom), 1'($urandom));
          end
        end
      end
      settle();
      calm <= 1'b0;
    end

    repeat (20) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $error("%0d predicted results never arrived", expected_lines.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Offer planned ticks; predict the result of each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_link(held_tick, pred_lines);
        expected_lines.push_back(pred_lines);
        tick_held = 1'b0;
      end
      if (!tick_held && pending_ticks.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        held_tick = pending_ticks.pop_front();
        tick_held = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 10){1'b0}}, held_tick.pulse, held_tick.sense, held_tick.tx};
        s_tuser  <= held_tick.mode;
      end else if (!tick_held) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    logic [OUT_DATA_W-1:0] want;
    int unsigned           e_val, a_val;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lines.size() == 0) begin
        $error("result 0x%04h arrived with no tick outstanding", m_tdata);
        fail_cnt++;
      end else begin
        want = expected_lines.pop_front();
        for (int f = 0; f < NFIELDS; f++) begin
          e_val = (want >> fld_lo[f]) & ((1 << fld_w[f]) - 1);
          a_val = (m_tdata >> fld_lo[f]) & ((1 << fld_w[f]) - 1);
          if (e_val != a_val) begin
            $error("%s: expected %0d, got %0d", fld_name[f], e_val, a_val);
            fail_cnt++;
          end
        end
      end
      results_seen <= results_seen + 1;
    end
    m_tready <= !rst && hold_left == 0 && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Hold the output off once for a long stretch so the input backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== tape_port_serial_link_host.f =====
design/tpsl_pkg.sv
design/tpsl_front.sv
design/tpsl_back.sv
design/tape_port_serial_link_host.sv
verif/testbench.sv
